>>> rtl/lbm_pkg.sv
package lbm_pkg;

  // Field and datapath widths
  localparam int unsigned DataW   = 16;
  localparam int unsigned InW     = 17;
  localparam int unsigned ResW    = 18;
  localparam int unsigned FuncW   = 5;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned NoiseW  = 8;
  localparam int unsigned ScaleW  = 9;
  localparam int unsigned CfgIdxW = 2;
  // Blended value before the mix, and multiplier operand width
  localparam int unsigned CalcW   = 20;
  // Product and mix accumulator width, and divider magnitude width
  localparam int unsigned AccW    = 37;
  localparam int unsigned DivW    = AccW - 1;
  localparam int unsigned CntW    = $clog2(DivW + 1);

  localparam logic [DataW-1:0] FullRatio = DataW'(255);
  localparam logic [DataW-1:0] ResetMax     = DataW'(255);
  localparam logic [DataW-1:0] ResetMid     = DataW'(128);
  localparam logic [DataW-1:0] ResetQuarter = DataW'(64);
  localparam logic [ScaleW-1:0] ResetScale  = ScaleW'(1);

  localparam logic signed [AccW-1:0] ResLow  = AccW'(-65536);
  localparam logic signed [AccW-1:0] ResHigh = AccW'(131071);

  typedef enum logic [FuncW-1:0] {
    MODE_NORMAL      = 5'd0,
    MODE_DISSOLVE    = 5'd1,
    MODE_THR_BOTTOM  = 5'd2,
    MODE_THR_TOP     = 5'd3,
    MODE_MULTIPLY    = 5'd4,
    MODE_SCREEN      = 5'd5,
    MODE_OVERLAY     = 5'd6,
    MODE_SOFT_LIGHT  = 5'd7,
    MODE_HARD_LIGHT  = 5'd8,
    MODE_DODGE       = 5'd9,
    MODE_BURN        = 5'd10,
    MODE_DARKEN      = 5'd11,
    MODE_LIGHTEN     = 5'd12,
    MODE_EXCLUSION   = 5'd13,
    MODE_DIFFERENCE  = 5'd14,
    MODE_NEG_DIFF1   = 5'd15,
    MODE_NEG_DIFF2   = 5'd16,
    MODE_SUBTRACT    = 5'd17,
    MODE_ADD         = 5'd18,
    MODE_EXPOSE      = 5'd19
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX     = 2'd0,
    REG_MID     = 2'd1,
    REG_QUARTER = 2'd2,
    REG_SCALE   = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_T1_MUL,
    S_T1_DSTART,
    S_T1_DWAIT,
    S_COMBINE,
    S_T2_MUL,
    S_T2_DSTART,
    S_T2_DWAIT,
    S_COMBINE2,
    S_MIX,
    S_MIX_MUL2,
    S_MIX_DSTART,
    S_MIX_DWAIT,
    S_THR_MUL,
    S_THR_CMP,
    S_WB
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [AccW-1:0]  dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [AccW-1:0] quotient;
  } div_rsp_t;

  // Clamp a signed input field to 0..hi
  function automatic logic [DataW-1:0] clamp_in(input logic signed [InW-1:0] v,
                                                input logic [DataW-1:0] hi);
    logic [DataW-1:0] w;
    if (v[InW-1]) begin
      w = '0;
    end else if (v[DataW-1:0] > hi) begin
      w = hi;
    end else begin
      w = v[DataW-1:0];
    end
    return w;
  endfunction

  // Saturate a wide signed value to the result range
  function automatic logic signed [ResW-1:0] sat_res(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] w;
    if (v < ResLow) begin
      w = ResLow;
    end else if (v > ResHigh) begin
      w = ResHigh;
    end else begin
      w = v;
    end
    return w[ResW-1:0];
  endfunction

  function automatic logic signed [CalcW-1:0] abs_diff(input logic signed [CalcW-1:0] x,
                                                       input logic signed [CalcW-1:0] y);
    logic signed [CalcW-1:0] w;
    if (x > y) begin
      w = x - y;
    end else begin
      w = y - x;
    end
    return w;
  endfunction

endpackage

>>> rtl/lbm_div.sv
// Restoring divider, one quotient bit per cycle. Signed dividend, positive
// divisor, quotient truncated toward zero.
module lbm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbm_pkg::div_req_t req_i,
  output lbm_pkg::div_rsp_t rsp_o
);

  logic [lbm_pkg::DivW-1:0]  quo_q, quo_d;
  logic [lbm_pkg::DataW-1:0] rem_q, rem_d;
  logic [lbm_pkg::DataW-1:0] dsr_q, dsr_d;
  logic [lbm_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [lbm_pkg::AccW-1:0]  res_q, res_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic                      neg_q, neg_d;
  logic [lbm_pkg::DataW:0]   shifted;
  logic [lbm_pkg::DataW:0]   diff;
  logic                      take;
  logic [lbm_pkg::AccW-1:0]  mag;

  // Step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[lbm_pkg::DivW-1]};
    take    = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
    mag     = req_i.dividend[lbm_pkg::AccW-1] ?
              (~req_i.dividend + lbm_pkg::AccW'(1)) : req_i.dividend;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    res_d  = res_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = lbm_pkg::CntW'(lbm_pkg::DivW);
      quo_d  = mag[lbm_pkg::DivW-1:0];
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      neg_d  = req_i.dividend[lbm_pkg::AccW-1];
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = take ? diff[lbm_pkg::DataW-1:0] : shifted[lbm_pkg::DataW-1:0];
        quo_d = {quo_q[lbm_pkg::DivW-2:0], take};
        cnt_d = cnt_q - 1'b1;
      end else begin
        // Apply the dividend sign to the quotient
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (~{1'b0, quo_q} + lbm_pkg::AccW'(1)) : {1'b0, quo_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

>>> rtl/layer_blend_modes.sv
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    func_i bottom_i top_i ratio_i channel_i random_value_i
// out      out_valid_o / out_ready_i  result_o bad_mode_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i cfg_data_i
//
// One item at a time: in_ready_o is high only while the sequencer is idle.
// An item needs 0 to 3 passes through the shared divider: none for early
// returns, dissolve, bad modes and the thresholds; the mix takes one unless
// the ratio is full, and the product modes take one more before it, two for
// exclusion. Reset restores the register defaults and clears the latched
// noise and colour. A stalled output holds the block in write-back only once
// the next result is ready; no further item is accepted meanwhile.
module layer_blend_modes (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lbm_pkg::FuncW-1:0]           func_i,
  input  logic signed [lbm_pkg::InW-1:0]      bottom_i,
  input  logic signed [lbm_pkg::InW-1:0]      top_i,
  input  logic signed [lbm_pkg::InW-1:0]      ratio_i,
  input  logic [lbm_pkg::ChanW-1:0]           channel_i,
  input  logic [lbm_pkg::NoiseW-1:0]          random_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lbm_pkg::ResW-1:0]     result_o,
  output logic                                bad_mode_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lbm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [lbm_pkg::DataW-1:0]           cfg_data_i
);

  lbm_pkg::state_e state_q, state_d;
  lbm_pkg::mode_e  mode_q, mode_d;

  logic [lbm_pkg::DataW-1:0]  max_q, max_d, mid_q, mid_d, quarter_q, quarter_d;
  logic [lbm_pkg::ScaleW-1:0] scale_q, scale_d;
  logic [lbm_pkg::NoiseW-1:0] noise_q, noise_d, rnd_q, rnd_d;
  logic [lbm_pkg::DataW-1:0]  colour_q, colour_d;
  logic [lbm_pkg::ChanW-1:0]  chan_q, chan_d;
  logic [lbm_pkg::DataW-1:0]  a_q, a_d, b_q, b_d, r_q, r_d;
  logic                       lo_q, lo_d;
  logic signed [lbm_pkg::CalcW-1:0] calc_q, calc_d;
  logic signed [lbm_pkg::AccW-1:0]  acc_q, acc_d;
  logic signed [lbm_pkg::ResW-1:0]  fin_q, fin_d, out_res_q, out_res_d;
  logic                       fin_bad_q, fin_bad_d, out_bad_q, out_bad_d;
  logic                       out_valid_q, out_valid_d;

  logic signed [lbm_pkg::CalcW-1:0]   a_s, b_s, mx_s, r_s, s_s, wr_s, mxb_s;
  logic signed [lbm_pkg::CalcW-1:0]   mul_x, mul_y;
  logic signed [2*lbm_pkg::CalcW-1:0] prod;
  logic signed [lbm_pkg::AccW-1:0]    q, mx_w, mxq, colour_w;
  logic                               out_free;
  logic                               chan_zero;

  lbm_pkg::div_req_t div_req;
  lbm_pkg::div_rsp_t div_rsp;

  lbm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Operand views
  assign a_s       = lbm_pkg::CalcW'(a_q);
  assign b_s       = lbm_pkg::CalcW'(b_q);
  assign r_s       = lbm_pkg::CalcW'(r_q);
  assign mx_s      = lbm_pkg::CalcW'(max_q);
  assign mxb_s     = mx_s - b_s;
  assign s_s       = lbm_pkg::CalcW'(a_q >> 1) + lbm_pkg::CalcW'(quarter_q);
  assign wr_s      = lbm_pkg::CalcW'(lbm_pkg::FullRatio) - r_s;
  assign prod      = mul_x * mul_y;
  assign q         = $signed(div_rsp.quotient);
  assign mx_w      = lbm_pkg::AccW'(max_q);
  assign mxq       = mx_w - q;
  assign colour_w  = lbm_pkg::AccW'(colour_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign chan_zero = chan_q == '0;

  assign in_ready_o  = state_q == lbm_pkg::S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_res_q;
  assign bad_mode_o  = out_bad_q;

  // Configuration writes
  always_comb begin
    max_d     = max_q;
    mid_d     = mid_q;
    quarter_d = quarter_q;
    scale_d   = scale_q;
    if (cfg_valid_i) begin
      case (lbm_pkg::cfg_reg_e'(cfg_index_i))
        lbm_pkg::REG_MAX:     max_d = cfg_data_i;
        lbm_pkg::REG_MID:     mid_d = cfg_data_i;
        lbm_pkg::REG_QUARTER: quarter_d = cfg_data_i;
        lbm_pkg::REG_SCALE:   scale_d = cfg_data_i[lbm_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbm_pkg::S_IDLE: begin
        if (in_valid_i) state_d = lbm_pkg::S_DECIDE;
      end
      lbm_pkg::S_DECIDE: begin
        if (mode_q > lbm_pkg::MODE_EXPOSE) begin
          state_d = lbm_pkg::S_WB;
        end else if ((r_q == lbm_pkg::FullRatio) && (mode_q < lbm_pkg::MODE_MULTIPLY)) begin
          state_d = lbm_pkg::S_WB;
        end else if (r_q == '0) begin
          state_d = lbm_pkg::S_WB;
        end else begin
          case (mode_q)
            lbm_pkg::MODE_DISSOLVE: state_d = lbm_pkg::S_WB;
            lbm_pkg::MODE_THR_BOTTOM,
            lbm_pkg::MODE_THR_TOP: state_d = lbm_pkg::S_THR_MUL;
            lbm_pkg::MODE_MULTIPLY,
            lbm_pkg::MODE_SCREEN,
            lbm_pkg::MODE_OVERLAY,
            lbm_pkg::MODE_SOFT_LIGHT,
            lbm_pkg::MODE_HARD_LIGHT,
            lbm_pkg::MODE_EXCLUSION: state_d = lbm_pkg::S_T1_MUL;
            lbm_pkg::MODE_DODGE: begin
              state_d = (b_q >= max_q) ? lbm_pkg::S_MIX : lbm_pkg::S_T1_MUL;
            end
            lbm_pkg::MODE_BURN: begin
              state_d = (b_q == '0) ? lbm_pkg::S_MIX : lbm_pkg::S_T1_MUL;
            end
            lbm_pkg::MODE_NORMAL,
            lbm_pkg::MODE_DARKEN,
            lbm_pkg::MODE_LIGHTEN,
            lbm_pkg::MODE_DIFFERENCE,
            lbm_pkg::MODE_NEG_DIFF1,
            lbm_pkg::MODE_NEG_DIFF2,
            lbm_pkg::MODE_SUBTRACT,
            lbm_pkg::MODE_ADD,
            lbm_pkg::MODE_EXPOSE: state_d = lbm_pkg::S_MIX;
            default: state_d = lbm_pkg::S_WB;
          endcase
        end
      end
      lbm_pkg::S_T1_MUL:    state_d = lbm_pkg::S_T1_DSTART;
      lbm_pkg::S_T1_DSTART: state_d = lbm_pkg::S_T1_DWAIT;
      lbm_pkg::S_T1_DWAIT: begin
        if (div_rsp.done) state_d = lbm_pkg::S_COMBINE;
      end
      lbm_pkg::S_COMBINE: begin
        state_d = (mode_q == lbm_pkg::MODE_EXCLUSION) ? lbm_pkg::S_T2_MUL : lbm_pkg::S_MIX;
      end
      lbm_pkg::S_T2_MUL:    state_d = lbm_pkg::S_T2_DSTART;
      lbm_pkg::S_T2_DSTART: state_d = lbm_pkg::S_T2_DWAIT;
      lbm_pkg::S_T2_DWAIT: begin
        if (div_rsp.done) state_d = lbm_pkg::S_COMBINE2;
      end
      lbm_pkg::S_COMBINE2: state_d = lbm_pkg::S_MIX;
      lbm_pkg::S_MIX: begin
        state_d = (r_q == lbm_pkg::FullRatio) ? lbm_pkg::S_WB : lbm_pkg::S_MIX_MUL2;
      end
      lbm_pkg::S_MIX_MUL2:   state_d = lbm_pkg::S_MIX_DSTART;
      lbm_pkg::S_MIX_DSTART: state_d = lbm_pkg::S_MIX_DWAIT;
      lbm_pkg::S_MIX_DWAIT: begin
        if (div_rsp.done) state_d = lbm_pkg::S_WB;
      end
      lbm_pkg::S_THR_MUL: state_d = lbm_pkg::S_THR_CMP;
      lbm_pkg::S_THR_CMP: state_d = lbm_pkg::S_WB;
      lbm_pkg::S_WB: begin
        if (out_free) state_d = lbm_pkg::S_IDLE;
      end
      default: state_d = lbm_pkg::S_IDLE;
    endcase
  end

  // Sequencer datapath control
  always_comb begin
    mode_d      = mode_q;
    chan_d      = chan_q;
    rnd_d       = rnd_q;
    a_d         = a_q;
    b_d         = b_q;
    r_d         = r_q;
    lo_d        = lo_q;
    calc_d      = calc_q;
    acc_d       = acc_q;
    fin_d       = fin_q;
    fin_bad_d   = fin_bad_q;
    noise_d     = noise_q;
    colour_d    = colour_q;
    mul_x       = a_s;
    mul_y       = b_s;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_bad_d   = out_bad_q;

    div_req.start    = 1'b0;
    div_req.dividend = acc_q;
    div_req.divisor  = max_q;

    case (state_q)
      lbm_pkg::S_IDLE: begin
        // Take the request and clamp its values
        if (in_valid_i) begin
          mode_d    = lbm_pkg::mode_e'(func_i);
          chan_d    = channel_i;
          rnd_d     = random_value_i;
          a_d       = lbm_pkg::clamp_in(bottom_i, max_q);
          b_d       = lbm_pkg::clamp_in(top_i, max_q);
          r_d       = lbm_pkg::clamp_in(ratio_i, max_q);
          fin_bad_d = 1'b0;
        end
      end
      lbm_pkg::S_DECIDE: begin
        if (mode_q > lbm_pkg::MODE_EXPOSE) begin
          fin_d     = lbm_pkg::sat_res(lbm_pkg::AccW'(a_q));
          fin_bad_d = 1'b1;
        end else if ((r_q == lbm_pkg::FullRatio) && (mode_q < lbm_pkg::MODE_MULTIPLY)) begin
          fin_d = lbm_pkg::sat_res(lbm_pkg::AccW'(b_q));
        end else if (r_q == '0) begin
          fin_d = lbm_pkg::sat_res(lbm_pkg::AccW'(a_q));
        end else begin
          case (mode_q)
            lbm_pkg::MODE_NORMAL: calc_d = b_s;
            lbm_pkg::MODE_DISSOLVE: begin
              // Latch noise on channel zero and compare against the live value there
              if (chan_zero) begin
                noise_d = rnd_q;
                fin_d = (r_q < lbm_pkg::DataW'(rnd_q)) ? lbm_pkg::ResW'(a_q)
                                                      : lbm_pkg::ResW'(b_q);
              end else begin
                fin_d = (r_q < lbm_pkg::DataW'(noise_q)) ? lbm_pkg::ResW'(a_q)
                                                        : lbm_pkg::ResW'(b_q);
              end
            end
            lbm_pkg::MODE_THR_BOTTOM: begin
              if (chan_zero) colour_d = a_q;
            end
            lbm_pkg::MODE_THR_TOP: begin
              if (chan_zero) colour_d = b_q;
            end
            lbm_pkg::MODE_OVERLAY,
            lbm_pkg::MODE_SOFT_LIGHT: lo_d = a_q < mid_q;
            lbm_pkg::MODE_HARD_LIGHT: lo_d = b_q < mid_q;
            lbm_pkg::MODE_DODGE: calc_d = mx_s;
            lbm_pkg::MODE_BURN: calc_d = '0;
            lbm_pkg::MODE_DARKEN: calc_d = (a_s < b_s) ? a_s : b_s;
            lbm_pkg::MODE_LIGHTEN: calc_d = (a_s > b_s) ? a_s : b_s;
            lbm_pkg::MODE_DIFFERENCE: calc_d = lbm_pkg::abs_diff(a_s, b_s);
            lbm_pkg::MODE_NEG_DIFF1: calc_d = mx_s - lbm_pkg::abs_diff(a_s, mxb_s);
            lbm_pkg::MODE_NEG_DIFF2: calc_d = lbm_pkg::abs_diff(mx_s - a_s, b_s);
            lbm_pkg::MODE_SUBTRACT: calc_d = a_s - b_s;
            lbm_pkg::MODE_ADD: calc_d = a_s + b_s;
            lbm_pkg::MODE_EXPOSE: calc_d = a_s + a_s - b_s;
            default: ;
          endcase
        end
      end
      lbm_pkg::S_T1_MUL: begin
        // Form the product that feeds the first division
        case (mode_q)
          lbm_pkg::MODE_SCREEN,
          lbm_pkg::MODE_EXCLUSION: begin
            mul_x = mx_s - a_s;
            mul_y = mxb_s;
          end
          lbm_pkg::MODE_OVERLAY,
          lbm_pkg::MODE_HARD_LIGHT: begin
            mul_x = lo_q ? (a_s + a_s) : ((mx_s - a_s) + (mx_s - a_s));
            mul_y = lo_q ? b_s : mxb_s;
          end
          lbm_pkg::MODE_SOFT_LIGHT: begin
            mul_x = lo_q ? (b_s + b_s) : ((mx_s - s_s) + (mx_s - s_s));
            mul_y = lo_q ? s_s : mxb_s;
          end
          lbm_pkg::MODE_DODGE: begin
            mul_x = a_s;
            mul_y = mx_s;
          end
          lbm_pkg::MODE_BURN: begin
            mul_x = mx_s - a_s;
            mul_y = mx_s;
          end
          default: begin
            mul_x = a_s;
            mul_y = b_s;
          end
        endcase
        acc_d = $signed(prod[lbm_pkg::AccW-1:0]);
      end
      lbm_pkg::S_T1_DSTART: begin
        div_req.start = 1'b1;
        case (mode_q)
          lbm_pkg::MODE_DODGE: div_req.divisor = max_q - b_q;
          lbm_pkg::MODE_BURN:  div_req.divisor = b_q;
          default:             div_req.divisor = max_q;
        endcase
      end
      lbm_pkg::S_COMBINE: begin
        // Fold the quotient into the blended value
        case (mode_q)
          lbm_pkg::MODE_SCREEN,
          lbm_pkg::MODE_EXCLUSION: calc_d = mxq[lbm_pkg::CalcW-1:0];
          lbm_pkg::MODE_OVERLAY,
          lbm_pkg::MODE_SOFT_LIGHT,
          lbm_pkg::MODE_HARD_LIGHT: begin
            calc_d = lo_q ? q[lbm_pkg::CalcW-1:0] : mxq[lbm_pkg::CalcW-1:0];
          end
          lbm_pkg::MODE_DODGE: begin
            calc_d = (q > mx_w) ? mx_s : q[lbm_pkg::CalcW-1:0];
          end
          lbm_pkg::MODE_BURN: begin
            calc_d = (mxq < 0) ? '0 : mxq[lbm_pkg::CalcW-1:0];
          end
          default: calc_d = q[lbm_pkg::CalcW-1:0];
        endcase
      end
      lbm_pkg::S_T2_MUL: begin
        mul_x = a_s;
        mul_y = b_s;
        acc_d = $signed(prod[lbm_pkg::AccW-1:0]);
      end
      lbm_pkg::S_T2_DSTART: begin
        div_req.start   = 1'b1;
        div_req.divisor = max_q;
      end
      lbm_pkg::S_COMBINE2: begin
        calc_d = calc_q - q[lbm_pkg::CalcW-1:0];
      end
      lbm_pkg::S_MIX: begin
        // Full ratio passes the blended value, else start the weighted sum
        mul_x = wr_s;
        mul_y = a_s;
        if (r_q == lbm_pkg::FullRatio) begin
          fin_d = lbm_pkg::sat_res(lbm_pkg::AccW'(calc_q));
        end else begin
          acc_d = $signed(prod[lbm_pkg::AccW-1:0]);
        end
      end
      lbm_pkg::S_MIX_MUL2: begin
        mul_x = r_s;
        mul_y = calc_q;
        acc_d = acc_q + $signed(prod[lbm_pkg::AccW-1:0]);
      end
      lbm_pkg::S_MIX_DSTART: begin
        div_req.start   = 1'b1;
        div_req.divisor = lbm_pkg::FullRatio;
      end
      lbm_pkg::S_MIX_DWAIT: begin
        if (div_rsp.done) fin_d = lbm_pkg::sat_res(q);
      end
      lbm_pkg::S_THR_MUL: begin
        mul_x = wr_s;
        mul_y = lbm_pkg::CalcW'(scale_q);
        acc_d = $signed(prod[lbm_pkg::AccW-1:0]);
      end
      lbm_pkg::S_THR_CMP: begin
        fin_d = (colour_w < acc_q) ? lbm_pkg::ResW'(a_q) : lbm_pkg::ResW'(b_q);
      end
      lbm_pkg::S_WB: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = fin_q;
          out_bad_d   = fin_bad_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      max_q       <= lbm_pkg::ResetMax;
      mid_q       <= lbm_pkg::ResetMid;
      quarter_q   <= lbm_pkg::ResetQuarter;
      scale_q     <= lbm_pkg::ResetScale;
      noise_q     <= '0;
      colour_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      max_q       <= max_d;
      mid_q       <= mid_d;
      quarter_q   <= quarter_d;
      scale_q     <= scale_d;
      noise_q     <= noise_d;
      colour_q    <= colour_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    chan_q    <= chan_d;
    rnd_q     <= rnd_d;
    a_q       <= a_d;
    b_q       <= b_d;
    r_q       <= r_d;
    lo_q      <= lo_d;
    calc_q    <= calc_d;
    acc_q     <= acc_d;
    fin_q     <= fin_d;
    fin_bad_q <= fin_bad_d;
    out_res_q <= out_res_d;
    out_bad_q <= out_bad_d;
  end

endmodule
